@@ rtl/core/orl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// orl_pkg
// shared widths, operation and status codes and cell control type for the
// ordered reference list
// ----------------------------------------------------------------------------
package orl_pkg;

  // storage defaults
  localparam int unsigned DEPTH_DEF     = 16;
  localparam int unsigned WORD_BITS_DEF = 32;

  // field widths of the channels
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned REF_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned CAP_W    = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // per-cell control
  typedef struct packed {
    logic load;   // take the appended word
    logic shift;  // take the word of the next cell up
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/core/orl_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// orl_req_if
// request channel: valid/ready handshake with operation, position and word
// ----------------------------------------------------------------------------
interface orl_req_if;
  logic                        valid;
  logic                        ready;
  logic [orl_pkg::FUNC_W-1:0]  func;
  logic [orl_pkg::POS_W-1:0]   position;
  logic [orl_pkg::REF_W-1:0]   ref_word;

  modport source (output valid, output func, output position, output ref_word, input ready);
  modport sink   (input valid, input func, input position, input ref_word, output ready);
endinterface
`default_nettype wire

@@ rtl/core/orl_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// orl_rsp_if
// response channel: valid/ready handshake with status, word, position, count
// ----------------------------------------------------------------------------
interface orl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [orl_pkg::STATUS_W-1:0]  status;
  logic [orl_pkg::REF_W-1:0]     out_word;
  logic [orl_pkg::POS_W-1:0]     found_position;
  logic [orl_pkg::COUNT_W-1:0]   entry_count;

  modport source (output valid, output status, output out_word, output found_position,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input out_word, input found_position,
                  input entry_count, output ready);
endinterface
`default_nettype wire

@@ rtl/core/orl_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// orl_cell
// one list entry: holds a word, compares it to the key, loads or shifts down
// ----------------------------------------------------------------------------
module orl_cell #(
  parameter int unsigned WORD_BITS = orl_pkg::WORD_BITS_DEF
) (
  input  wire                     clk_i,
  input  orl_pkg::cell_ctrl_t     ctrl_i,
  input  wire  [WORD_BITS-1:0]    load_word_i,
  input  wire  [WORD_BITS-1:0]    next_word_i,
  input  wire  [WORD_BITS-1:0]    key_i,
  output logic [WORD_BITS-1:0]    word_o,
  output logic                    match_o
);

  logic [WORD_BITS-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    if (ctrl_i.load) begin
      word_d = load_word_i;
    end else if (ctrl_i.shift) begin
      word_d = next_word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o  = word_q;
  assign match_o = (word_q == key_i);

endmodule
`default_nettype wire

@@ rtl/core/ordered_reference_list_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_reference_list_top
// ordered list of nonzero reference words held in a row of cells, with
// append, pop by position, remove by value and clear
// ----------------------------------------------------------------------------
//
//  port      | dir | handshake        | carries
//  ----------+-----+------------------+------------------------------------------
//  req_i     | in  | valid/ready      | func, position, ref_word
//  rsp_o     | out | valid/ready      | status, out_word, found_position, count
//  cfg_*_i   | in  | write enable     | capacity_limit (5 bits)
//
//  a transaction first captures the request, then every cell compares against
//  the key and shifts down in parallel
//  the result sits in an output register; the next request is taken while it
//  waits, and the cell update cycle holds only while that register is full
//  reset clears the count and sets capacity_limit to 16; cell contents are
//  not reset and are only read below the count
//
module ordered_reference_list_top #(
  parameter int unsigned DEPTH     = orl_pkg::DEPTH_DEF,
  parameter int unsigned WORD_BITS = orl_pkg::WORD_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  orl_req_if.sink                      req_i,
  orl_rsp_if.source                    rsp_o,
  input  wire                          cfg_we_i,
  input  wire  [orl_pkg::CAP_W-1:0]    cfg_wdata_i
);

  // count holds 0..DEPTH; compares are done in a width that fits count,
  // capacity limit and position
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CMP_W = (CNT_W > orl_pkg::CAP_W) ? CNT_W : orl_pkg::CAP_W;

  // two-state sequencer
  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;

  // captured request
  logic [orl_pkg::FUNC_W-1:0] func_q;
  logic [orl_pkg::POS_W-1:0]  pos_q;
  logic [orl_pkg::REF_W-1:0]  ref_q;

  // list control state
  logic [CNT_W-1:0]          count_q, count_d;
  logic [orl_pkg::CAP_W-1:0] cap_q;

  // output register
  logic                         out_valid_q;
  logic [orl_pkg::STATUS_W-1:0] out_status_q, status_d;
  logic [orl_pkg::REF_W-1:0]    out_word_q;
  logic [orl_pkg::POS_W-1:0]    out_pos_q, found_pos_d;
  logic [orl_pkg::COUNT_W-1:0]  out_count_q;

  logic req_fire;
  logic exec_fire;

  // cell row signals
  logic [WORD_BITS-1:0]        key_w;
  logic [WORD_BITS-1:0]        cell_word [DEPTH];
  logic [DEPTH-1:0]            cell_eq;
  logic [DEPTH-1:0]            in_use;
  logic [DEPTH-1:0]            match;
  logic [DEPTH-1:0]            del;
  orl_pkg::cell_ctrl_t         cell_ctrl [DEPTH];

  logic [CMP_W-1:0] count_ext;
  logic [CMP_W-1:0] pos_ext;
  logic             key_null;
  logic             list_full;
  logic             do_append;
  logic             any_del;
  logic [IDX_W-1:0] del_idx;
  logic [WORD_BITS-1:0] del_word;

  // --------------------------------------------------------------------------
  // handshake
  // --------------------------------------------------------------------------
  assign req_i.ready = (state_q == StIdle);
  assign req_fire    = req_i.valid && req_i.ready;
  // cells update only when the output register can take the result
  assign exec_fire   = (state_q == StExec) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (req_fire) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (exec_fire) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      func_q <= req_i.func;
      pos_q  <= req_i.position;
      ref_q  <= req_i.ref_word;
    end
  end

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= orl_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // --------------------------------------------------------------------------
  // request decode
  // --------------------------------------------------------------------------
  // word narrowed or zero-extended to the storage width
  assign key_w     = WORD_BITS'(ref_q);
  assign key_null  = (key_w == '0);
  assign count_ext = CMP_W'(count_q);
  assign pos_ext   = CMP_W'(pos_q);

  // limit saturates at DEPTH; a limit of zero makes the list always full
  assign list_full = (count_ext >= CMP_W'(cap_q)) || (count_ext >= CMP_W'(DEPTH));
  assign do_append = exec_fire && (func_q == orl_pkg::FUNC_APPEND) && !key_null && !list_full;

  // --------------------------------------------------------------------------
  // row of cells
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CMP_W-1:0] IdxC      = CMP_W'(i);
    localparam logic [DEPTH-1:0] BelowMask = {DEPTH{1'b1}} >> (DEPTH - i);
    localparam logic [DEPTH-1:0] UpToMask  = {DEPTH{1'b1}} >> (DEPTH - 1 - i);

    logic [WORD_BITS-1:0] next_word;

    assign in_use[i] = (IdxC < count_ext);
    assign match[i]  = cell_eq[i] && in_use[i] && !key_null;

    // deletion target: position for pop, first equal entry for remove
    always_comb begin
      del[i] = 1'b0;
      case (func_q)
        orl_pkg::FUNC_POP:    del[i] = in_use[i] && (IdxC == pos_ext);
        orl_pkg::FUNC_REMOVE: del[i] = match[i] && !(|(match & BelowMask));
        default:              del[i] = 1'b0;
      endcase
    end

    // every cell at or above the deleted one takes its upper neighbor
    assign cell_ctrl[i].shift = exec_fire && (|(del & UpToMask));
    assign cell_ctrl[i].load  = do_append && (IdxC == count_ext);

    if (i == DEPTH - 1) begin : g_last
      assign next_word = cell_word[i];
    end else begin : g_mid
      assign next_word = cell_word[i+1];
    end

    orl_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl[i]),
      .load_word_i (key_w),
      .next_word_i (next_word),
      .key_i       (key_w),
      .word_o      (cell_word[i]),
      .match_o     (cell_eq[i])
    );
  end

  // one-hot deletion target to index and word
  always_comb begin
    del_idx  = '0;
    del_word = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (del[k]) begin
        del_idx  = del_idx | IDX_W'(k);
        del_word = del_word | cell_word[k];
      end
    end
  end

  assign any_del = |del;

  // --------------------------------------------------------------------------
  // result and count
  // --------------------------------------------------------------------------
  always_comb begin
    status_d    = orl_pkg::ST_OK;
    found_pos_d = '0;
    count_d     = count_q;
    case (func_q)
      orl_pkg::FUNC_APPEND: begin
        if (key_null) begin
          status_d = orl_pkg::ST_NULL;
        end else if (list_full) begin
          status_d = orl_pkg::ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      orl_pkg::FUNC_POP: begin
        if (any_del) begin
          count_d = count_q - CNT_W'(1);
        end else begin
          status_d = orl_pkg::ST_NOT_FOUND;
        end
      end
      orl_pkg::FUNC_REMOVE: begin
        if (any_del) begin
          count_d     = count_q - CNT_W'(1);
          found_pos_d = orl_pkg::POS_W'(del_idx);
        end else begin
          status_d = orl_pkg::ST_NOT_FOUND;
        end
      end
      orl_pkg::FUNC_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (exec_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      out_status_q <= status_d;
      out_word_q   <= orl_pkg::REF_W'(del_word);
      out_pos_q    <= found_pos_d;
      out_count_q  <= orl_pkg::COUNT_W'(count_d);
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.out_word       = out_word_q;
  assign rsp_o.found_position = out_pos_q;
  assign rsp_o.entry_count    = out_count_q;

`ifndef SYNTHESIS
  // at most one entry is deleted per transaction
  a_del_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StExec) |-> $onehot0(del))
    else $error("more than one deletion target");

  // count never exceeds the number of cells
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire |=> (CMP_W'(count_q) <= CMP_W'(DEPTH)))
    else $error("entry count beyond depth");

  // clear empties the list
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_fire && (func_q == orl_pkg::FUNC_CLEAR)) |=> (count_q == '0))
    else $error("clear left entries");

  // a successful append grows the list by exactly one
  a_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_append |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("append did not grow the count");

  // a new result only appears after a cell update
  a_rsp_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(exec_fire))
    else $error("result without update");
`endif

endmodule
`default_nettype wire

@@ verif/orl_list_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orl_list_checker
// watches the request, response and capacity ports of the ordered reference
// list, keeps its own copy of the list, predicts every response and compares
// each accepted response field by field with the oldest prediction
// ----------------------------------------------------------------------------
module orl_list_checker (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  orl_req_if                        req,
  orl_rsp_if                        rsp,
  input  wire                       cfg_we_i,
  input  wire  [orl_pkg::CAP_W-1:0] cfg_wdata_i,
  output int                        fail_count_o,
  output int                        pending_o
);
  import orl_pkg::*;

  localparam int unsigned LIST_DEPTH = DEPTH_DEF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [REF_W-1:0]    out_word;
    logic [POS_W-1:0]    found_position;
    logic [COUNT_W-1:0]  entry_count;
  } list_result_t;

  logic [REF_W-1:0]   list_words [LIST_DEPTH];
  logic [COUNT_W-1:0] entry_cnt;
  logic [CAP_W-1:0]   cap_limit;
  list_result_t       pending_results [$];
  int                 errors = 0;
  int                 result_no = 0;

  task automatic report_error(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want)
      report_error($sformatf("response %0d: %s is 0x%0h, expected 0x%0h",
                             result_no, name, got, want));
  endtask

  // delete one entry and close the gap
  function automatic logic [REF_W-1:0] take_entry(input int unsigned at);
    logic [REF_W-1:0] w;
    w = list_words[at];
    for (int unsigned i = at; i + 1 < entry_cnt; i++)
      list_words[i] = list_words[i + 1];
    entry_cnt = entry_cnt - 1'b1;
    return w;
  endfunction

  function automatic list_result_t next_list_result(input logic [FUNC_W-1:0] op,
                                                    input logic [POS_W-1:0]  pos,
                                                    input logic [REF_W-1:0]  word);
    list_result_t       r;
    logic [COUNT_W-1:0] lim;
    bit                 hit;
    r   = '0;
    hit = 1'b0;
    lim = (cap_limit > LIST_DEPTH) ? COUNT_W'(LIST_DEPTH) : cap_limit;
    case (op)
      FUNC_APPEND: begin
        if (word == '0) begin
          r.status = ST_NULL;
        end else if (entry_cnt >= lim) begin
          r.status = ST_FULL;
        end else begin
          list_words[entry_cnt] = word;
          entry_cnt = entry_cnt + 1'b1;
        end
      end
      FUNC_POP: begin
        if (pos >= entry_cnt) r.status = ST_NOT_FOUND;
        else r.out_word = take_entry(pos);
      end
      FUNC_REMOVE: begin
        r.status = ST_NOT_FOUND;
        // a null key never matches
        for (int i = 0; i < entry_cnt && !hit; i++) begin
          if (word != '0 && list_words[i] == word) begin
            hit              = 1'b1;
            r.status         = ST_OK;
            r.found_position = POS_W'(i);
            r.out_word       = take_entry(i);
          end
        end
      end
      default: entry_cnt = '0;
    endcase
    r.entry_count = entry_cnt;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      entry_cnt = '0;
      cap_limit = CAP_RESET;
      pending_results.delete();
    end else begin
      if (cfg_we_i) cap_limit = cfg_wdata_i;
      if (rsp.valid && rsp.ready) begin
        result_no++;
        if (pending_results.size() == 0) begin
          report_error($sformatf("response %0d with nothing outstanding", result_no));
        end else begin
          want = pending_results.pop_front();
          check_field("status", want.status, rsp.status);
          check_field("out_word", want.out_word, rsp.out_word);
          check_field("found_position", want.found_position, rsp.found_position);
          check_field("entry_count", want.entry_count, rsp.entry_count);
        end
      end
      if (req.valid && req.ready)
        pending_results.push_back(next_list_result(req.func, req.position, req.ref_word));
    end
    fail_count_o <= errors;
    pending_o    <= pending_results.size();
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the ordered reference list: directed corner
// requests, then phases of random requests under varied capacity settings
// with bursty requests, random output stalls and one long output hold-off
// ----------------------------------------------------------------------------
module tb_top;
  import orl_pkg::*;

  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 96;
  localparam int HOLD_PHASE      = 1;    // list is near full here
  localparam int HOLD_CYCLES     = 200;
  localparam int SETTLE_CYCLES   = 4;    // lets the capture and cell update finish, plus margin
  localparam int LIMIT_NS        = 3_200_000;

  // mix of operations within a phase
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_e;
  // output stall patterns
  typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_EVERY_THIRD, RX_MOSTLY} rx_mode_e;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;
  bit               hold_req = 1'b0;
  int               fail_count;
  int               pending;
  int               sent_count = 0;
  int               cfg_writes = 0;
  logic [REF_W-1:0] word_pool [8];

  // capacity per phase: extremes, values above depth, and a drop below count
  logic [CAP_W-1:0] phase_cap [NUM_PHASES] =
    '{5'd16, 5'd16, 5'd3, 5'd0, 5'd1, 5'd31, 5'd8, 5'd16, 5'd2, 5'd17, 5'd15, 5'd16};
  op_mix_e phase_mix [NUM_PHASES] =
    '{MIX_FILL, MIX_FILL, MIX_EVEN, MIX_EVEN, MIX_DRAIN, MIX_FILL,
      MIX_EVEN, MIX_DRAIN, MIX_EVEN, MIX_FILL, MIX_EVEN, MIX_DRAIN};

  orl_req_if req_if ();
  orl_rsp_if rsp_if ();

  ordered_reference_list_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  orl_list_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req          (req_if),
    .rsp          (rsp_if),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    #(LIMIT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: random stall pattern, switched to a new one at random, plus
  // one long hold-off when the stimulus asks for it
  initial begin
    rx_mode_e mode;
    int       mode_left;
    int       hold_left;
    bit       hold_taken;
    int       cyc;
    rsp_if.ready = 1'b0;
    mode       = RX_ALWAYS;
    mode_left  = 0;
    hold_left  = 0;
    hold_taken = 1'b0;
    cyc        = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 4));
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        case (mode)
          RX_ALWAYS:      rsp_if.ready <= 1'b1;
          RX_HALF:        rsp_if.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE:      rsp_if.ready <= ($urandom_range(0, 3) == 0);
          RX_EVERY_THIRD: rsp_if.ready <= (cyc % 3 == 0);
          default:        rsp_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // offer one request and hold it until the block takes it; valid stays
  // high so back-to-back transactions need no extra step
  task automatic send_req(input logic [FUNC_W-1:0] op, input logic [POS_W-1:0] pos,
                          input logic [REF_W-1:0] word);
    req_if.valid    <= 1'b1;
    req_if.func     <= op;
    req_if.position <= pos;
    req_if.ref_word <= word;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sent_count++;
  endtask

  // sender gap with junk on the payload
  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      req_if.valid    <= 1'b0;
      req_if.func     <= FUNC_W'($urandom);
      req_if.position <= POS_W'($urandom);
      req_if.ref_word <= $urandom;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // wait until every outstanding response has come back
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cap(input logic [CAP_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_writes++;
  endtask

  // small pool of keys so that remove often hits, plus the bit extremes
  task automatic refresh_pool();
    word_pool[0] = 32'hFFFF_FFFF;
    word_pool[1] = 32'h0000_0001;
    word_pool[2] = 32'h8000_0000;
    for (int i = 3; i < 8; i++) word_pool[i] = $urandom;
  endtask

  function automatic logic [REF_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 25) return $urandom;
    return word_pool[$urandom_range(0, 7)];
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    if ($urandom_range(0, 1) == 0) return POS_W'($urandom_range(0, 3));
    return POS_W'($urandom_range(0, 15));
  endfunction

  function automatic logic [FUNC_W-1:0] pick_op(input op_mix_e mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:
        return r < 75 ? FUNC_APPEND : r < 85 ? FUNC_POP : r < 98 ? FUNC_REMOVE : FUNC_CLEAR;
      MIX_DRAIN:
        return r < 25 ? FUNC_APPEND : r < 60 ? FUNC_POP : r < 98 ? FUNC_REMOVE : FUNC_CLEAR;
      default:
        return r < 45 ? FUNC_APPEND : r < 70 ? FUNC_POP : r < 97 ? FUNC_REMOVE : FUNC_CLEAR;
    endcase
  endfunction

  initial begin
    int burst_left;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = CAP_RESET;
    req_if.valid    = 1'b0;
    req_if.func     = FUNC_APPEND;
    req_if.position = '0;
    req_if.ref_word = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset capacity of 16
    send_req(FUNC_APPEND, 4'd0,  32'h0);            // null append rejected
    send_req(FUNC_POP,    4'd0,  32'hDEAD_BEEF);    // pop from empty list
    send_req(FUNC_REMOVE, 4'd0,  32'h5);            // remove from empty list
    send_req(FUNC_CLEAR,  4'd9,  32'h0);            // clear when already empty
    send_req(FUNC_APPEND, 4'd15, 32'hFFFF_FFFF);
    send_req(FUNC_APPEND, 4'd0,  32'h0000_0001);
    send_req(FUNC_APPEND, 4'd7,  32'h8000_0000);
    send_req(FUNC_APPEND, 4'd0,  32'hFFFF_FFFF);    // duplicate key
    send_req(FUNC_REMOVE, 4'd0,  32'hFFFF_FFFF);    // first match wins
    send_req(FUNC_REMOVE, 4'd0,  32'h0);            // null search never matches
    send_req(FUNC_POP,    4'd15, 32'h0);            // position beyond count
    send_req(FUNC_POP,    4'd2,  32'h0);            // pop the tail
    send_req(FUNC_POP,    4'd0,  32'h0);            // pop the head, compaction
    send_req(FUNC_REMOVE, 4'd3,  32'h8000_0000);    // last entry goes
    wait_idle();
    write_cap(5'd1);                                // smallest useful limit
    send_req(FUNC_APPEND, 4'd0,  32'h0000_0007);
    send_req(FUNC_APPEND, 4'd0,  32'h0000_0009);    // full
    send_req(FUNC_POP,    4'd0,  32'h0);
    send_req(FUNC_APPEND, 4'd0,  32'h0000_000A);
    send_req(FUNC_CLEAR,  4'd0,  32'h0);
    wait_idle();
    write_cap(5'd0);                                // every append is full
    send_req(FUNC_APPEND, 4'd0,  32'h0000_0003);

    // random phases; the list carries over, so lowering the limit below the
    // current count happens naturally
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_cap(phase_cap[p]);
      refresh_pool();
      if (p == HOLD_PHASE) hold_req <= 1'b1;
      burst_left = 0;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // every third phase runs without sender gaps
        if (p % 3 != 2 && burst_left == 0) begin
          idle_gap($urandom_range(0, 6));
          burst_left = $urandom_range(1, 12);
        end
        send_req(pick_op(phase_mix[p]), pick_pos(), pick_word());
        if (burst_left > 0) burst_left--;
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("summary: %0d requests over %0d capacity writes, bursty input, random stalls",
             sent_count, cfg_writes);
    $display("summary: one %0d-cycle output hold-off with the request side backed up",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
